// ----- design/tpwm_pkg.sv -----
// Package: shared types and constants of the three-phase center-aligned PWM unit.
package tpwm_pkg;

  localparam int CNT_W   = 16;
  localparam int DT_W    = 6;
  localparam int PHASES  = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] PERIOD_RST = 16'd4199;
  localparam logic [DT_W-1:0]  DEAD_RST   = 6'd8;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_DUTY    = 2'd1,
    FUNC_ENABLE  = 2'd2,
    FUNC_DISABLE = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_DEAD   = 1'b1
  } cfg_idx_t;

  // Control handed from the counter to each phase.
  typedef struct packed {
    logic tick;
    logic update;
    logic load;
    logic enabled;
  } phase_ctrl_t;

  typedef struct packed {
    logic high;
    logic low;
  } gates_t;

  typedef struct packed {
    gates_t [PHASES-1:0] gates;
    logic [CNT_W-1:0]    count_value;
    logic                counting_down;
    logic                update_event;
    logic                running;
  } result_t;

endpackage

// ----- design/tpwm_in_if.sv -----
// Interface: input item channel of the PWM unit.
interface tpwm_in_if;
  logic                      valid;
  logic                      ready;
  tpwm_pkg::func_t           func;
  logic [tpwm_pkg::CNT_W-1:0] duty_a;
  logic [tpwm_pkg::CNT_W-1:0] duty_b;
  logic [tpwm_pkg::CNT_W-1:0] duty_c;

  modport source (output valid, func, duty_a, duty_b, duty_c, input ready);
  modport sink   (input valid, func, duty_a, duty_b, duty_c, output ready);
endinterface

// ----- design/tpwm_out_if.sv -----
// Interface: result item channel of the PWM unit.
interface tpwm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      gate_a_high;
  logic                      gate_a_low;
  logic                      gate_b_high;
  logic                      gate_b_low;
  logic                      gate_c_high;
  logic                      gate_c_low;
  logic [tpwm_pkg::CNT_W-1:0] count_value;
  logic                      counting_down;
  logic                      update_event;
  logic                      running;

  modport source (output valid, gate_a_high, gate_a_low, gate_b_high, gate_b_low,
                  gate_c_high, gate_c_low, count_value, counting_down,
                  update_event, running, input ready);
  modport sink   (input valid, gate_a_high, gate_a_low, gate_b_high, gate_b_low,
                  gate_c_high, gate_c_low, count_value, counting_down,
                  update_event, running, output ready);
endinterface

// ----- design/three_phase_center_aligned_pwm_unit.sv -----
// Top level: three-phase center-aligned complementary PWM unit with dead time.
// Each accepted item is one timer event: a tick, a duty write, an enable or a
// disable. The unit takes one item per clock cycle while in_ch.ready is high
// and returns one registered result item per input item; counter, compare and
// dead-time logic are combinational. A two-deep result stage (output register
// plus skid register) decouples the channels, so in_ch.ready drops only while
// both hold results the sink has not taken. The gates shown in a result are
// those after the item's effect; duty writes take effect at the next turning
// point of the up/down counter. Configuration (period top, dead-time ticks)
// must be written by the user through cfg while the unit is idle (unchecked).
module three_phase_center_aligned_pwm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tpwm_in_if.sink                        in_ch,
  tpwm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpwm_pkg::CFG_W-1:0]     cfg_data
);

  logic [tpwm_pkg::CNT_W-1:0] period_r;
  logic [tpwm_pkg::DT_W-1:0]  dead_time_r;

  logic [tpwm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       down_r, down_nxt;
  logic                       en_r, en_nxt;
  logic                       event_nxt;
  logic                       do_tick;
  logic                       in_fire, out_fire;
  logic [tpwm_pkg::CNT_W:0]   cnt_inc;

  tpwm_pkg::phase_ctrl_t                        pctrl;
  tpwm_pkg::gates_t [tpwm_pkg::PHASES-1:0]      gates;
  logic [tpwm_pkg::PHASES-1:0][tpwm_pkg::CNT_W-1:0] duty;
  tpwm_pkg::result_t                            res;
  tpwm_pkg::result_t                            out_r, skid_r;
  logic                                         out_valid_r, skid_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= tpwm_pkg::PERIOD_RST;
      dead_time_r <= tpwm_pkg::DEAD_RST;
    end else if (cfg_we) begin
      case (tpwm_pkg::cfg_idx_t'(cfg_index))
        tpwm_pkg::CFG_PERIOD: period_r    <= cfg_data[tpwm_pkg::CNT_W-1:0];
        tpwm_pkg::CFG_DEAD:   dead_time_r <= cfg_data[tpwm_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign do_tick     = in_fire && (in_ch.func == tpwm_pkg::FUNC_TICK) && en_r;
  assign cnt_inc     = {1'b0, cnt_r} + 1'b1;

  // up/down counter
  always_comb begin
    cnt_nxt   = cnt_r;
    down_nxt  = down_r;
    event_nxt = 1'b0;
    if (do_tick) begin
      if (!down_r) begin
        if (cnt_inc >= {1'b0, period_r}) begin
          cnt_nxt   = period_r;
          down_nxt  = 1'b1;
          event_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_inc[tpwm_pkg::CNT_W-1:0];
        end
      end else begin
        if (cnt_r <= tpwm_pkg::CNT_W'(1)) begin
          cnt_nxt   = '0;
          down_nxt  = 1'b0;
          event_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_comb begin
    en_nxt = en_r;
    if (in_fire) begin
      case (in_ch.func)
        tpwm_pkg::FUNC_ENABLE:  en_nxt = 1'b1;
        tpwm_pkg::FUNC_DISABLE: en_nxt = 1'b0;
        default:                en_nxt = en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      down_r <= 1'b0;
      en_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      down_r <= down_nxt;
      en_r   <= en_nxt;
    end
  end

  assign pctrl.tick    = do_tick;
  assign pctrl.update  = event_nxt;
  assign pctrl.load    = in_fire && (in_ch.func == tpwm_pkg::FUNC_DUTY);
  assign pctrl.enabled = en_nxt;

  assign duty[0] = in_ch.duty_a;
  assign duty[1] = in_ch.duty_b;
  assign duty[2] = in_ch.duty_c;

  for (genvar p = 0; p < tpwm_pkg::PHASES; p++) begin : g_phase
    tpwm_phase u_phase (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (pctrl),
      .cnt_nxt   (cnt_nxt),
      .period    (period_r),
      .dead_time (dead_time_r),
      .duty      (duty[p]),
      .gates     (gates[p])
    );
  end

  assign res.gates         = gates;
  assign res.count_value   = cnt_nxt;
  assign res.counting_down = down_nxt;
  assign res.update_event  = event_nxt;
  assign res.running       = en_nxt;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.gate_a_high   = out_r.gates[0].high;
  assign out_ch.gate_a_low    = out_r.gates[0].low;
  assign out_ch.gate_b_high   = out_r.gates[1].high;
  assign out_ch.gate_b_low    = out_r.gates[1].low;
  assign out_ch.gate_c_high   = out_r.gates[2].high;
  assign out_ch.gate_c_low    = out_r.gates[2].low;
  assign out_ch.count_value   = out_r.count_value;
  assign out_ch.counting_down = out_r.counting_down;
  assign out_ch.update_event  = out_r.update_event;
  assign out_ch.running       = out_r.running;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while output register is empty");

  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ch.gate_a_high && out_ch.gate_a_low) &&
                    !(out_ch.gate_b_high && out_ch.gate_b_low) &&
                    !(out_ch.gate_c_high && out_ch.gate_c_low))
    else $error("both gates of a phase on");

  a_stopped_gates_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.running) |->
      !(out_ch.gate_a_high || out_ch.gate_a_low || out_ch.gate_b_high ||
        out_ch.gate_b_low || out_ch.gate_c_high || out_ch.gate_c_low) &&
      !out_ch.update_event)
    else $error("gate or update active while stopped");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> skid_valid_r && out_valid_r)
    else $error("result dropped while sink stalls");

endmodule

// ----- design/tpwm_phase.sv -----
// One PWM phase: compare preload, reference compare and dead-time insertion.
module tpwm_phase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tpwm_pkg::phase_ctrl_t      ctrl,
  input  logic [tpwm_pkg::CNT_W-1:0] cnt_nxt,
  input  logic [tpwm_pkg::CNT_W-1:0] period,
  input  logic [tpwm_pkg::DT_W-1:0]  dead_time,
  input  logic [tpwm_pkg::CNT_W-1:0] duty,
  output tpwm_pkg::gates_t           gates
);

  logic [tpwm_pkg::CNT_W-1:0] preload_r, preload_nxt;
  logic [tpwm_pkg::CNT_W-1:0] active_r, active_nxt;
  logic [tpwm_pkg::DT_W-1:0]  dead_r, dead_nxt;
  logic                       last_r, last_nxt;
  logic                       ref_lvl;
  logic                       gate_on;

  always_comb begin
    preload_nxt = preload_r;
    if (ctrl.load) begin
      // clamp to the period
      preload_nxt = (duty > period) ? period : duty;
    end
    active_nxt = (ctrl.tick && ctrl.update) ? preload_r : active_r;
    ref_lvl    = cnt_nxt < active_nxt;
    last_nxt   = last_r;
    dead_nxt   = dead_r;
    if (ctrl.tick) begin
      if (ref_lvl != last_r) begin
        last_nxt = ref_lvl;
        dead_nxt = dead_time;
      end else if (dead_r != '0) begin
        dead_nxt = dead_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preload_r <= '0;
      active_r  <= '0;
      dead_r    <= '0;
      last_r    <= 1'b0;
    end else begin
      preload_r <= preload_nxt;
      active_r  <= active_nxt;
      dead_r    <= dead_nxt;
      last_r    <= last_nxt;
    end
  end

  assign gate_on    = ctrl.enabled && (dead_nxt == '0);
  assign gates.high = gate_on && last_nxt;
  assign gates.low  = gate_on && !last_nxt;

endmodule
